/* rtl/cehacc_pkg.sv */
// ============================================================================
// cehacc_pkg: shared types and constants
// Payload structs, command and status codes for the cell hit accumulator.
// ============================================================================
package cehacc_pkg;

    localparam int MAX_HITS_DEF = 256;

    typedef enum logic [1:0] {
        CMD_DEPOSIT = 2'd0,
        CMD_CLEAR   = 2'd1,
        CMD_READ    = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_ACCUM    = 3'd0,
        ST_NEW      = 3'd1,
        ST_ZERO     = 3'd2,
        ST_FULL     = 3'd3,
        ST_CLEARED  = 3'd4,
        ST_READ_OK  = 3'd5,
        ST_READ_OOR = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]         command;
        logic [19:0]        cell_id;
        logic [31:0]        deposit_energy;
        logic               is_em_particle;
        logic [31:0]        step_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [7:0]         read_index;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         entry_index;
        logic [8:0]         hit_count;
        logic [19:0]        entry_cell_id;
        logic [31:0]        entry_energy;
        logic [31:0]        entry_em_energy;
        logic [31:0]        entry_time;
        logic signed [31:0] entry_pos_x;
        logic signed [31:0] entry_pos_y;
        logic signed [31:0] entry_pos_z;
    } t_out;

    // one table entry as held in a cell
    typedef struct packed {
        logic [19:0] cell_id;
        logic [31:0] energy;
        logic [31:0] em_energy;
        logic [31:0] t;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
    } t_entry;

    // operation broadcast to every cell
    typedef struct packed {
        logic        upd;     // accumulate into selected cell
        logic        wr;      // write new entry into selected cell
        logic        em;
        logic [31:0] e;
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_OUT
    } t_state;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

/* rtl/cehacc_cell.sv */
// ============================================================================
// cehacc_cell: one table entry
// Holds an entry, compares it against the key broadcast to every cell and
// passes the earliest match (index and contents) to the next cell.
// ============================================================================
module cehacc_cell #(
    parameter int IW = 8
) (
    input  logic                 i_clk,
    input  logic [IW-1:0]        i_my_idx,
    input  logic                 i_filled,
    input  logic [19:0]          i_key,
    input  logic                 i_by_idx,
    input  logic [IW-1:0]        i_key_idx,
    input  logic                 i_sel,
    input  cehacc_pkg::t_cell_op i_op,
    input  cehacc_pkg::t_entry   i_new,
    input  logic                 i_hit,
    input  logic [IW-1:0]        i_hit_idx,
    input  cehacc_pkg::t_entry   i_hit_entry,
    output logic                 o_hit,
    output logic [IW-1:0]        o_hit_idx,
    output cehacc_pkg::t_entry   o_hit_entry
);
    import cehacc_pkg::*;

    t_entry r_entry;
    logic   match;

    always_ff @(posedge i_clk) begin
        if (i_sel && i_op.wr) begin
            r_entry <= i_new;
        end else if (i_sel && i_op.upd) begin
            r_entry.energy <= sat_add(r_entry.energy, i_op.e);
            if (i_op.em) begin
                r_entry.em_energy <= sat_add(r_entry.em_energy, i_op.e);
            end
        end
    end

    // a read matches on the entry position, a deposit on the stored id
    assign match       = i_filled && (i_by_idx ? (i_my_idx == i_key_idx)
                                               : (r_entry.cell_id == i_key));
    assign o_hit       = i_hit || match;
    assign o_hit_idx   = i_hit ? i_hit_idx : i_my_idx;
    assign o_hit_entry = i_hit ? i_hit_entry : r_entry;
endmodule

/* rtl/cell_energy_hit_accumulator.sv */
// ============================================================================
// cell_energy_hit_accumulator: per-event calorimeter cell hit table
// Chain of entry cells with a registered match search and a small sequencer.
// ============================================================================
// Input channel i_valid/o_ready carries deposit, clear and read items; the
// output channel o_valid/i_ready returns exactly one result per item.
// Items are processed one at a time: accept, scan, apply, present. The id
// search runs along the chain of MAX_HITS cells: each cell forwards the
// earliest match, and the chain is broken into registered groups of 16 so
// the search takes one scan cycle per group. The scan covers
// NG = ceil(MAX_HITS/16) groups, the result is registered in the apply
// state and presented in the out state, and a new item is taken the cycle
// after the result is transferred. A read searches the same chain by
// entry position instead of by id.
// Reset clears the fill count and the sequencer; entry contents are not
// cleared and no clearing pass is needed. A stalled receiver holds the
// result and the block takes no new item until it is transferred.
// ============================================================================
module cell_energy_hit_accumulator #(
    parameter int MAX_HITS = cehacc_pkg::MAX_HITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  cehacc_pkg::t_in  i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output cehacc_pkg::t_out o_data
);
    import cehacc_pkg::*;

    localparam int IW   = $clog2(MAX_HITS);
    localparam int CW   = $clog2(MAX_HITS + 1);
    localparam int GRP  = 16;
    localparam int NG   = (MAX_HITS + GRP - 1) / GRP;
    localparam int GW   = (NG > 1) ? $clog2(NG) : 1;

    t_state           r_state, n_state;
    t_in              r_in;
    logic [CW-1:0]    r_count;
    logic [GW-1:0]    r_grp;
    logic             r_hit;
    logic [IW-1:0]    r_hit_idx;
    t_entry           r_hit_entry;
    t_out             r_out;

    logic   [MAX_HITS:0] c_hit;
    logic   [IW-1:0]     c_idx   [MAX_HITS+1];
    t_entry              c_entry [MAX_HITS+1];
    logic   [MAX_HITS-1:0] sel;
    t_cell_op            op;
    t_entry              new_e;
    logic                g_hit;
    logic   [IW-1:0]     g_idx;
    t_entry              g_entry;
    logic                full;
    logic   [IW-1:0]     rd_idx;
    logic                rd_mode;
    logic                rd_in_range;

    assign full = (r_count == CW'(MAX_HITS));

    assign rd_idx      = IW'(r_in.read_index);
    assign rd_mode     = (r_in.command == CMD_READ);
    assign rd_in_range = (32'(r_in.read_index) < 32'(MAX_HITS));

    assign new_e.cell_id   = r_in.cell_id;
    assign new_e.energy    = r_in.deposit_energy;
    assign new_e.em_energy = r_in.is_em_particle ? r_in.deposit_energy : 32'd0;
    assign new_e.t         = r_in.step_time;
    assign new_e.px        = r_in.pos_x;
    assign new_e.py        = r_in.pos_y;
    assign new_e.pz        = r_in.pos_z;

    assign c_hit[0]   = 1'b0;
    assign c_idx[0]   = '0;
    assign c_entry[0] = '0;

    // group heads restart the chain; group outputs are folded in r_hit
    genvar gi;
    generate
        for (gi = 0; gi < MAX_HITS; gi++) begin : g_cell
            logic   in_hit;
            logic   [IW-1:0] in_idx;
            t_entry in_entry;
            assign in_hit   = (gi % GRP == 0) ? 1'b0 : c_hit[gi];
            assign in_idx   = c_idx[gi];
            assign in_entry = c_entry[gi];
            cehacc_cell #(.IW(IW)) u_cell (
                .i_clk       (i_clk),
                .i_my_idx    (IW'(gi)),
                .i_filled    (CW'(gi) < r_count),
                .i_key       (r_in.cell_id),
                .i_by_idx    (rd_mode),
                .i_key_idx   (rd_idx),
                .i_sel       (sel[gi]),
                .i_op        (op),
                .i_new       (new_e),
                .i_hit       (in_hit),
                .i_hit_idx   (in_idx),
                .i_hit_entry (in_entry),
                .o_hit       (c_hit[gi+1]),
                .o_hit_idx   (c_idx[gi+1]),
                .o_hit_entry (c_entry[gi+1])
            );
        end
    endgenerate

    // select the tail of the current group
    always_comb begin
        g_hit   = 1'b0;
        g_idx   = '0;
        g_entry = '0;
        for (int g = 0; g < NG; g++) begin
            if (GW'(g) == r_grp) begin
                g_hit   = c_hit[((g + 1) * GRP > MAX_HITS) ? MAX_HITS : (g + 1) * GRP];
                g_idx   = c_idx[((g + 1) * GRP > MAX_HITS) ? MAX_HITS : (g + 1) * GRP];
                g_entry = c_entry[((g + 1) * GRP > MAX_HITS) ? MAX_HITS : (g + 1) * GRP];
            end
        end
    end

    logic deposit_ok;
    assign deposit_ok = (r_in.command == CMD_DEPOSIT) && (r_in.deposit_energy != 32'd0);

    always_comb begin
        op     = '0;
        op.e   = r_in.deposit_energy;
        op.em  = r_in.is_em_particle;
        sel    = '0;
        if (r_state == S_APPLY && deposit_ok) begin
            if (r_hit) begin
                op.upd = 1'b1;
                sel[r_hit_idx] = 1'b1;
            end else if (!full) begin
                op.wr = 1'b1;
                sel[r_count[IW-1:0]] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_SCAN;
            S_SCAN:  if (r_grp == GW'(NG - 1)) n_state = S_APPLY;
            S_APPLY: n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_in <= i_data;
        end
        if (r_state == S_IDLE) begin
            r_grp     <= '0;
            r_hit     <= 1'b0;
        end else if (r_state == S_SCAN) begin
            if (!r_hit && g_hit) begin
                r_hit       <= 1'b1;
                r_hit_idx   <= g_idx;
                r_hit_entry <= g_entry;
            end
            if (r_grp != GW'(NG - 1)) begin
                r_grp <= r_grp + 1'b1;
            end
        end
    end

    // build the result; stored contents come from the scan
    always_ff @(posedge i_clk) begin
        if (r_state == S_APPLY) begin
            r_out             <= '0;
            r_out.status      <= ST_ZERO;
            r_out.hit_count   <= 9'(r_count);
            case (r_in.command)
                CMD_DEPOSIT: begin
                    if (r_in.deposit_energy != 32'd0) begin
                        if (r_hit) begin
                            r_out.status          <= ST_ACCUM;
                            r_out.entry_index     <= 8'(r_hit_idx);
                            r_out.entry_cell_id   <= r_hit_entry.cell_id;
                            r_out.entry_energy    <= sat_add(r_hit_entry.energy,
                                                             r_in.deposit_energy);
                            r_out.entry_em_energy <= r_in.is_em_particle
                                ? sat_add(r_hit_entry.em_energy, r_in.deposit_energy)
                                : r_hit_entry.em_energy;
                            r_out.entry_time      <= r_hit_entry.t;
                            r_out.entry_pos_x     <= r_hit_entry.px;
                            r_out.entry_pos_y     <= r_hit_entry.py;
                            r_out.entry_pos_z     <= r_hit_entry.pz;
                        end else if (!full) begin
                            r_out.status          <= ST_NEW;
                            r_out.entry_index     <= 8'(r_count);
                            r_out.hit_count       <= 9'(r_count + 1'b1);
                            r_out.entry_cell_id   <= new_e.cell_id;
                            r_out.entry_energy    <= new_e.energy;
                            r_out.entry_em_energy <= new_e.em_energy;
                            r_out.entry_time      <= new_e.t;
                            r_out.entry_pos_x     <= new_e.px;
                            r_out.entry_pos_y     <= new_e.py;
                            r_out.entry_pos_z     <= new_e.pz;
                        end else begin
                            r_out.status <= ST_FULL;
                        end
                    end
                end
                CMD_CLEAR: begin
                    r_out.status    <= ST_CLEARED;
                    r_out.hit_count <= '0;
                end
                CMD_READ: begin
                    r_out.entry_index <= r_in.read_index;
                    // only filled entries match, so a hit means the index is below the count
                    if (r_hit && rd_in_range) begin
                        r_out.status          <= ST_READ_OK;
                        r_out.entry_cell_id   <= r_hit_entry.cell_id;
                        r_out.entry_energy    <= r_hit_entry.energy;
                        r_out.entry_em_energy <= r_hit_entry.em_energy;
                        r_out.entry_time      <= r_hit_entry.t;
                        r_out.entry_pos_x     <= r_hit_entry.px;
                        r_out.entry_pos_y     <= r_hit_entry.py;
                        r_out.entry_pos_z     <= r_hit_entry.pz;
                    end else begin
                        r_out.status <= ST_READ_OOR;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_state == S_APPLY) begin
            if (r_in.command == CMD_CLEAR) begin
                r_count <= '0;
            end else if (deposit_ok && !r_hit && !full) begin
                r_count <= r_count + 1'b1;
            end
        end
    end
endmodule

/* rtl/cehacc_checker.sv */
// ============================================================================
// cehacc_checker: port-level checks
// Watches the handshake and result codes on the top level's ports.
// ============================================================================
module cehacc_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input cehacc_pkg::t_out o_data
);
    import cehacc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_CLEARED |-> o_data.hit_count == 9'd0)
        else $error("clear reports nonzero count");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input taken while result pending");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second transfer taken while busy");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.status != 3'd7)
        else $error("bad status code");
endmodule

bind cell_energy_hit_accumulator cehacc_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

/* verif/tb_cell_energy_hit_accumulator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cell_energy_hit_accumulator: self-checking bench for the cell hit table
// Drives deposit, clear and read items in random bursts against a stalling
// receiver and compares every result with a behavioral copy of the table.
// ----------------------------------------------------------------------------
module tb_cell_energy_hit_accumulator;
    import cehacc_pkg::*;

    localparam int TABLE_DEPTH = MAX_HITS_DEF;
    localparam int CYCLE_LIMIT = 1000000;

    class hit_table_scoreboard;
        logic [19:0] cell_id_mem[TABLE_DEPTH];
        logic [31:0] energy_mem[TABLE_DEPTH];
        logic [31:0] em_energy_mem[TABLE_DEPTH];
        logic [31:0] time_mem[TABLE_DEPTH];
        logic [31:0] px_mem[TABLE_DEPTH];
        logic [31:0] py_mem[TABLE_DEPTH];
        logic [31:0] pz_mem[TABLE_DEPTH];
        int unsigned fill;
        t_out pending_results[$];
        int errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        function logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function void load_entry(ref t_out r, input int unsigned k);
            r.entry_cell_id   = cell_id_mem[k];
            r.entry_energy    = energy_mem[k];
            r.entry_em_energy = em_energy_mem[k];
            r.entry_time      = time_mem[k];
            r.entry_pos_x     = px_mem[k];
            r.entry_pos_y     = py_mem[k];
            r.entry_pos_z     = pz_mem[k];
        endfunction

        function void note_input(t_in it);
            t_out r;
            int match;
            r = '0;
            r.status = ST_ZERO;
            case (t_cmd'(it.command))
                CMD_DEPOSIT: begin
                    if (it.deposit_energy != 0) begin
                        match = -1;
                        for (int k = 0; k < fill; k++) begin
                            if (match < 0 && cell_id_mem[k] == it.cell_id) match = k;
                        end
                        if (match >= 0) begin
                            energy_mem[match] = add_clamped(energy_mem[match],
                                                            it.deposit_energy);
                            if (it.is_em_particle)
                                em_energy_mem[match] = add_clamped(em_energy_mem[match],
                                                                   it.deposit_energy);
                            r.status = ST_ACCUM;
                            r.entry_index = match[7:0];
                            load_entry(r, match);
                        end else if (fill < TABLE_DEPTH) begin
                            cell_id_mem[fill]   = it.cell_id;
                            energy_mem[fill]    = it.deposit_energy;
                            em_energy_mem[fill] = it.is_em_particle ? it.deposit_energy : '0;
                            time_mem[fill]      = it.step_time;
                            px_mem[fill]        = it.pos_x;
                            py_mem[fill]        = it.pos_y;
                            pz_mem[fill]        = it.pos_z;
                            r.status = ST_NEW;
                            r.entry_index = fill[7:0];
                            load_entry(r, fill);
                            fill++;
                        end else begin
                            r.status = ST_FULL;
                        end
                    end
                end
                CMD_CLEAR: begin
                    fill = 0;
                    r.status = ST_CLEARED;
                end
                CMD_READ: begin
                    r.entry_index = it.read_index;
                    if (it.read_index < fill) begin
                        r.status = ST_READ_OK;
                        load_entry(r, it.read_index);
                    end else begin
                        r.status = ST_READ_OOR;
                    end
                end
                default: ;
            endcase
            r.hit_count = fill[8:0];
            pending_results.push_back(r);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                $display("%0t: result mismatch expected %h actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, i_ready, o_ready, o_valid;
    t_in  i_data;
    t_out o_data;

    hit_table_scoreboard hit_sb;
    t_in  item_queue[$];
    int   cycle_count;
    bit   hold_off;
    bit   stim_done;

    cell_energy_hit_accumulator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_in rand_item();
        t_in it;
        it = '0;
        it.command        = 2'($urandom_range(0, 3));
        it.cell_id        = 20'($urandom);
        it.deposit_energy = $urandom;
        it.is_em_particle = 1'($urandom);
        it.step_time      = $urandom;
        it.pos_x          = $urandom;
        it.pos_y          = $urandom;
        it.pos_z          = $urandom;
        it.read_index     = 8'($urandom);
        return it;
    endfunction

    // deposit item; random ones use a small id pool for matches and saturation
    function automatic t_in make_deposit(logic [19:0] id, logic [31:0] e, bit em);
        t_in it;
        it = rand_item();
        it.command = CMD_DEPOSIT;
        it.cell_id = id;
        it.deposit_energy = e;
        it.is_em_particle = em;
        return it;
    endfunction

    function automatic t_in make_cmd(t_cmd c, logic [7:0] idx);
        t_in it;
        it = rand_item();
        it.command = c;
        it.read_index = idx;
        return it;
    endfunction

    task automatic build_stimulus();
        t_in it;
        int pick;
        // directed
        item_queue.push_back(make_cmd(CMD_READ, 8'd0));
        item_queue.push_back(make_deposit(20'h0, 32'd0, 1'b1));
        item_queue.push_back(make_deposit(20'hFFFFF, 32'hFFFF_FFF0, 1'b1));
        item_queue.push_back(make_deposit(20'hFFFFF, 32'hFFFF_FFFF, 1'b1));
        item_queue.push_back(make_deposit(20'hFFFFF, 32'd5, 1'b0));
        it = make_deposit(20'h0, 32'd1, 1'b0);
        it.step_time = '1; it.pos_x = 32'h8000_0000; it.pos_y = 32'h7FFF_FFFF;
        it.pos_z = '1;
        item_queue.push_back(it);
        item_queue.push_back(make_cmd(CMD_READ, 8'd1));
        item_queue.push_back(make_cmd(CMD_READ, 8'd2));
        item_queue.push_back(make_cmd(CMD_READ, 8'hFF));
        item_queue.push_back(make_cmd(CMD_NONE, 8'd0));
        item_queue.push_back(make_cmd(CMD_CLEAR, 8'd0));
        item_queue.push_back(make_cmd(CMD_READ, 8'd0));
        // fill the table completely, then probe full behavior
        for (int k = 0; k < TABLE_DEPTH; k++)
            item_queue.push_back(make_deposit(20'(k * 3 + 7), $urandom | 1, 1'($urandom)));
        item_queue.push_back(make_deposit(20'h12345, 32'd9, 1'b1));
        item_queue.push_back(make_deposit(20'd7, 32'hFFFF_FFFF, 1'b1));
        item_queue.push_back(make_cmd(CMD_READ, 8'hFF));
        item_queue.push_back(make_cmd(CMD_READ, 8'd0));
        item_queue.push_back(make_cmd(CMD_CLEAR, 8'd0));
        // random
        for (int n = 0; n < 330; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                it = make_deposit(20'($urandom_range(0, 15)),
                                  ($urandom_range(0, 9) == 0) ? 32'd0 :
                                  (($urandom_range(0, 7) == 0) ? $urandom | 32'hF000_0000
                                   : 32'($urandom_range(1, 100000))), 1'($urandom));
            else if (pick < 66) it = make_deposit(20'($urandom), $urandom, 1'($urandom));
            else if (pick < 88) it = make_cmd(CMD_READ, 8'($urandom_range(0, 20)));
            else if (pick < 93) it = make_cmd(CMD_CLEAR, 8'd0);
            else it = rand_item();
            item_queue.push_back(it);
        end
    endtask

    // sender: bursts with random gaps
    initial begin
        int burst, gap;
        i_valid = 1'b0;
        i_data = '0;
        stim_done = 1'b0;
        hit_sb = new();
        build_stimulus();
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (item_queue.size() > 0) begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && item_queue.size() > 0) begin
                i_valid <= 1'b1;
                i_data <= item_queue[0];
                @(posedge i_clk);
                while (!o_ready) @(posedge i_clk);
                hit_sb.note_input(item_queue.pop_front());
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: own stall pattern plus one long hold-off
    initial begin
        int phase;
        i_ready = 1'b0;
        hold_off = 1'b0;
        phase = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            phase++;
            if (phase == 2000) hold_off = 1'b1;
            if (phase == 2300) hold_off = 1'b0;
            if (hold_off) i_ready <= 1'b0;
            else if ((phase / 500) % 3 == 2) i_ready <= 1'b1;
            else i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) hit_sb.check_result(o_data);
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        wait (stim_done);
        while (hit_sb.pending_results.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (hit_sb.errors == 0 && hit_sb.pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
